### src/rtpjb_pkg.sv
// ============================================================================
// rtpjb_pkg - shared types and constants of the RTP jitter buffer
// Field widths, status and function codes, register indexes and the
// descriptor layout kept in the reorder ring.
// ============================================================================
`default_nettype none

package rtpjb_pkg;

    localparam int SEQ_W   = 16;
    localparam int TAG_W   = 32;
    localparam int LEN_W   = 16;
    localparam int TIME_W  = 32;
    localparam int DLY_W   = 16;
    localparam int CNTR_W  = 7;
    localparam int CIDX_W  = 2;
    localparam int CDATA_W = 16;

    // Operation codes
    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Register indexes
    localparam logic [CIDX_W-1:0] CFG_CAPACITY  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_MAX_DELAY = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_MIN_FILL  = 2'd2;

    // Register reset values
    localparam logic [CNTR_W-1:0] CAPACITY_RESET  = 7'd64;
    localparam logic [DLY_W-1:0]  MAX_DELAY_RESET = 16'd100;
    localparam logic [CNTR_W-1:0] MIN_FILL_RESET  = 7'd0;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic [CNTR_W-1:0] capacity;
        logic [DLY_W-1:0]  max_delay;
        logic [CNTR_W-1:0] min_fill;
    } t_cfg;

    typedef struct packed {
        logic              func;
        logic [SEQ_W-1:0]  seq;
        logic [TAG_W-1:0]  tag;
        logic [LEN_W-1:0]  len;
        logic [TIME_W-1:0] now;
    } t_item;

    typedef struct packed {
        t_status          status;
        logic             valid;
        logic [SEQ_W-1:0] seq;
        logic [TAG_W-1:0] tag;
        logic [LEN_W-1:0] len;
        logic [SEQ_W-1:0] lost;
    } t_result;

    typedef struct packed {
        logic              valid;
        logic [SEQ_W-1:0]  seq;
        logic [TAG_W-1:0]  tag;
        logic [LEN_W-1:0]  len;
        logic [TIME_W-1:0] stamp;
    } t_entry;

endpackage

`default_nettype wire

### src/rtp_jitter_buffer.sv
// ============================================================================
// rtp_jitter_buffer - reorder ring for sequence-numbered packets
// Stores packet descriptors by sequence offset and hands them out in
// sequence order, dropping expired entries.
// ============================================================================
// One item is handled at a time. Every item first reduces the stored read
// pointer by the ring capacity in a bit-serial remainder unit. An add then
// dispatches and does a read-modify-write of the target slot (only the
// dispatch when it is dropped or overflows), then hands off its result.
// A read scans the ring memory one slot per cycle through its single read
// port after dispatch; a read that underflows on fill level ends at
// dispatch. Results wait in an output register, so the next item is taken
// while one waits. After reset a clearing pass writes every ring slot once
// before the first item is accepted; configuration writes are taken at any
// time.
`default_nettype none

module rtp_jitter_buffer
    import rtpjb_pkg::*;
#(
    parameter int RING_DEPTH = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Configuration write channel
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [CIDX_W-1:0]  i_cfg_index,
    input  wire logic [CDATA_W-1:0] i_cfg_data,
    // Input stream
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [95:0]        s_axis_tdata,  // seq_num, payload_tag,
                                                   // payload_length, now_ms
    input  wire logic [0:0]         s_axis_tuser,  // func
    // Output stream
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [79:0]             m_axis_tdata,  // out_seq, out_tag,
                                                   // out_length, lost_count
    output logic [2:0]              m_axis_tuser   // status, out_valid
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int NW = (AW + 2 > 8) ? AW + 2 : 8;

    t_cfg          r_cfg;
    t_item         w_item;
    t_result       w_res;
    t_result       r_out;
    logic          r_out_vld;
    logic          w_res_valid, w_res_take;
    logic          w_ram_we;
    logic [AW-1:0] w_ram_waddr, w_ram_raddr;
    t_entry        w_ram_wdata, w_ram_rdata;
    logic          w_mod_start, w_mod_done;
    logic [AW-1:0] w_mod_dividend, w_mod_rem;
    logic [NW-1:0] w_mod_divisor;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.capacity  <= CAPACITY_RESET;
            r_cfg.max_delay <= MAX_DELAY_RESET;
            r_cfg.min_fill  <= MIN_FILL_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CAPACITY:  r_cfg.capacity  <= i_cfg_data[CNTR_W-1:0];
                CFG_MAX_DELAY: r_cfg.max_delay <= i_cfg_data[DLY_W-1:0];
                CFG_MIN_FILL:  r_cfg.min_fill  <= i_cfg_data[CNTR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Unpack the input beat
    assign w_item.func = s_axis_tuser[0];
    assign w_item.seq  = s_axis_tdata[15:0];
    assign w_item.tag  = s_axis_tdata[47:16];
    assign w_item.len  = s_axis_tdata[63:48];
    assign w_item.now  = s_axis_tdata[95:64];

    rtpjb_core #(
        .RING_DEPTH (RING_DEPTH),
        .AW         (AW),
        .NW         (NW)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_in_valid     (s_axis_tvalid),
        .o_in_ready     (s_axis_tready),
        .i_item         (w_item),
        .o_res_valid    (w_res_valid),
        .i_res_ready    (w_res_take),
        .o_res          (w_res),
        .o_ram_we       (w_ram_we),
        .o_ram_waddr    (w_ram_waddr),
        .o_ram_wdata    (w_ram_wdata),
        .o_ram_raddr    (w_ram_raddr),
        .i_ram_rdata    (w_ram_rdata),
        .o_mod_start    (w_mod_start),
        .o_mod_dividend (w_mod_dividend),
        .o_mod_divisor  (w_mod_divisor),
        .i_mod_done     (w_mod_done),
        .i_mod_rem      (w_mod_rem)
    );

    rtpjb_ram #(
        .DEPTH (RING_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    rtpjb_mod #(
        .AW (AW),
        .NW (NW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (w_mod_dividend),
        .i_divisor  (w_mod_divisor),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    // Output register: take a result when empty or draining
    assign w_res_take = !r_out_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_res_take) begin
            r_out_vld <= w_res_valid;
        end
        if (w_res_take && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out.lost, r_out.len, r_out.tag, r_out.seq};
    assign m_axis_tuser  = {r_out.valid, r_out.status};

    // An accepted beat moves the sequencer out of idle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready after accepting a beat");

    // A finished result lands in the output register
    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid && w_res_take |=> m_axis_tvalid)
        else $error("result lost on the way to the output register");

    // A delivered packet always carries status ok
    a_delivery_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == ST_OK)
        else $error("delivered packet with error status");

endmodule

`default_nettype wire

### src/rtpjb_ram.sv
// ============================================================================
// rtpjb_ram - descriptor ring storage
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module rtpjb_ram
    import rtpjb_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_entry        i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output t_entry             o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read one entry into a registered output
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### src/rtpjb_mod.sv
// ============================================================================
// rtpjb_mod - read pointer reduction
// Restoring remainder of the stored read pointer by the ring capacity,
// one dividend bit per cycle.
// ============================================================================
`default_nettype none

module rtpjb_mod
    import rtpjb_pkg::*;
#(
    parameter int AW = 6,
    parameter int NW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [AW-1:0] i_dividend,
    input  wire logic [NW-1:0] i_divisor,
    output logic               o_done,
    output logic [AW-1:0]      o_rem
);

    localparam int CW = $clog2(AW + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [NW-1:0] r_rem, n_rem;
    logic [AW-1:0] r_quo, n_quo;
    logic [NW-1:0] w_shift;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        w_shift = {r_rem[NW-2:0], r_quo[AW-1]};
        if (i_start) begin
            // Load a new dividend
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
        end else if (r_busy) begin
            // Shift in one bit and subtract the divisor when it fits
            n_rem = (w_shift >= i_divisor) ? (w_shift - i_divisor) : w_shift;
            n_quo = r_quo << 1;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(AW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[AW-1:0];

endmodule

`default_nettype wire

### src/rtpjb_core.sv
// ============================================================================
// rtpjb_core - jitter buffer sequencer
// Clears the ring after reset, places added descriptors, scans the ring on
// reads clearing expired and delivered slots, and hands out one result.
// ============================================================================
`default_nettype none

module rtpjb_core
    import rtpjb_pkg::*;
#(
    parameter int RING_DEPTH = 64,
    parameter int AW         = 6,
    parameter int NW         = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_cfg          i_cfg,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire t_item         i_item,
    output logic               o_res_valid,
    input  wire logic          i_res_ready,
    output t_result            o_res,
    output logic               o_ram_we,
    output logic [AW-1:0]      o_ram_waddr,
    output t_entry             o_ram_wdata,
    output logic [AW-1:0]      o_ram_raddr,
    input  wire t_entry        i_ram_rdata,
    output logic               o_mod_start,
    output logic [AW-1:0]      o_mod_dividend,
    output logic [NW-1:0]      o_mod_divisor,
    input  wire logic          i_mod_done,
    input  wire logic [AW-1:0] i_mod_rem
);

    localparam logic [NW-1:0] DEPTH_N = NW'(RING_DEPTH);
    localparam logic [NW-1:0] CAP_MIN = NW'(2);
    localparam logic [AW-1:0] LAST_IX = AW'(RING_DEPTH - 1);

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_MOD, S_DISP, S_ADD_WR, S_SCAN, S_RES
    } t_state;

    t_state           r_state, n_state;
    t_item            r_item, n_item;
    t_result          r_res, n_res;
    logic [AW-1:0]    r_read_ptr, n_read_ptr;
    logic [NW-1:0]    r_fill, n_fill;
    logic [SEQ_W-1:0] r_min_seq, n_min_seq;
    logic             r_started, n_started;
    logic [AW-1:0]    r_rp, n_rp;
    logic [AW-1:0]    r_idx, n_idx;
    logic [NW-1:0]    r_cnt, n_cnt;
    logic             r_chk_vld, n_chk_vld;
    logic [AW-1:0]    r_chk_idx, n_chk_idx;
    logic [AW-1:0]    r_slot, n_slot;

    logic [NW-1:0]    w_cap_raw, w_cap, w_cap_m1;
    logic [NW-1:0]    w_fill_dec, w_min_fill;
    logic [SEQ_W-1:0] w_eff_min, w_off, w_ahead, w_cap16;
    logic [NW-1:0]    w_sum, w_idx_inc, w_chk_inc;
    logic [TIME_W-1:0] w_age;
    logic             w_expired, w_live, w_found;

    // Clamp the capacity into its legal range
    always_comb begin
        w_cap_raw = {{(NW-CNTR_W){1'b0}}, i_cfg.capacity};
        if (w_cap_raw < CAP_MIN) begin
            w_cap = CAP_MIN;
        end else if (w_cap_raw > DEPTH_N) begin
            w_cap = DEPTH_N;
        end else begin
            w_cap = w_cap_raw;
        end
    end

    // Shared arithmetic
    always_comb begin
        w_cap_m1   = w_cap - 1'b1;
        w_cap16    = {{(SEQ_W-NW){1'b0}}, w_cap};
        w_min_fill = {{(NW-CNTR_W){1'b0}}, i_cfg.min_fill};
        w_fill_dec = (r_fill != '0) ? (r_fill - 1'b1) : r_fill;
        w_eff_min  = r_started ? r_min_seq : r_item.seq;
        w_off      = r_item.seq - w_eff_min;
        w_sum      = {{(NW-AW){1'b0}}, r_rp} + {{(NW-AW){1'b0}}, w_off[AW-1:0]};
        if (w_sum >= w_cap) begin
            w_sum = w_sum - w_cap;
        end
        w_idx_inc  = {{(NW-AW){1'b0}}, r_idx} + 1'b1;
        w_chk_inc  = {{(NW-AW){1'b0}}, r_chk_idx} + 1'b1;
        w_age      = r_item.now - i_ram_rdata.stamp;
        w_ahead    = i_ram_rdata.seq - r_min_seq;
        w_expired  = r_chk_vld && i_ram_rdata.valid
                  && (w_age > {{(TIME_W-DLY_W){1'b0}}, i_cfg.max_delay});
        w_live     = r_chk_vld && i_ram_rdata.valid && !w_expired && !w_ahead[SEQ_W-1];
        w_found    = w_live;
    end

    // Next state
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_res       = r_res;
        n_read_ptr  = r_read_ptr;
        n_fill      = r_fill;
        n_min_seq   = r_min_seq;
        n_started   = r_started;
        n_rp        = r_rp;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_chk_vld   = 1'b0;
        n_chk_idx   = r_chk_idx;
        n_slot      = r_slot;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_idx;
        o_ram_wdata = i_ram_rdata;
        o_ram_raddr = r_idx;
        o_mod_start = 1'b0;

        unique case (r_state)
            S_CLR: begin
                // Sweep the ring, one slot a cycle
                o_ram_we          = 1'b1;
                o_ram_waddr       = r_idx;
                o_ram_wdata       = '0;
                n_idx             = r_idx + 1'b1;
                if (r_idx == LAST_IX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item      = i_item;
                    o_mod_start = 1'b1;
                    n_state     = S_MOD;
                end
            end
            S_MOD: begin
                if (i_mod_done) begin
                    n_rp    = i_mod_rem;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_res   = '0;
                n_state = S_RES;
                if (r_item.func == FUNC_ADD) begin
                    n_min_seq = w_eff_min;
                    n_started = 1'b1;
                    if (w_off[SEQ_W-1]) begin
                        // Drop an old packet quietly
                        n_res.status = ST_OK;
                    end else if (r_fill >= w_cap || w_off >= w_cap16) begin
                        n_res.status = ST_OVERFLOW;
                    end else begin
                        // Fetch the target slot to learn whether it is taken
                        n_slot      = w_sum[AW-1:0];
                        o_ram_raddr = w_sum[AW-1:0];
                        n_state     = S_ADD_WR;
                    end
                end else if (r_fill < w_min_fill) begin
                    n_res.status = ST_UNDERFLOW;
                end else begin
                    n_idx   = r_rp;
                    n_cnt   = '0;
                    n_state = S_SCAN;
                end
            end
            S_ADD_WR: begin
                // Write the descriptor, count a newly taken slot
                if (!i_ram_rdata.valid) begin
                    n_fill = r_fill + 1'b1;
                end
                o_ram_we          = 1'b1;
                o_ram_waddr       = r_slot;
                o_ram_wdata.valid = 1'b1;
                o_ram_wdata.seq   = r_item.seq;
                o_ram_wdata.tag   = r_item.tag;
                o_ram_wdata.len   = r_item.len;
                o_ram_wdata.stamp = r_item.now;
                n_res.status      = ST_OK;
                n_state           = S_RES;
            end
            S_SCAN: begin
                // Examine the slot fetched last cycle
                o_ram_waddr       = r_chk_idx;
                o_ram_wdata.valid = 1'b0;
                if (w_expired) begin
                    o_ram_we = 1'b1;
                    n_fill   = w_fill_dec;
                end else if (w_found) begin
                    o_ram_we     = 1'b1;
                    n_fill       = w_fill_dec;
                    n_res.status = ST_OK;
                    n_res.valid  = 1'b1;
                    n_res.seq    = i_ram_rdata.seq;
                    n_res.tag    = i_ram_rdata.tag;
                    n_res.len    = i_ram_rdata.len;
                    n_res.lost   = w_ahead;
                    n_read_ptr   = (w_chk_inc >= w_cap) ? '0 : w_chk_inc[AW-1:0];
                    n_min_seq    = i_ram_rdata.seq + 1'b1;
                    n_state      = S_RES;
                end
                // Fetch the next slot while the scan goes on
                if (!w_found) begin
                    if (r_cnt < w_cap_m1) begin
                        o_ram_raddr = r_idx;
                        n_chk_vld   = 1'b1;
                        n_chk_idx   = r_idx;
                        n_cnt       = r_cnt + 1'b1;
                        n_idx       = (w_idx_inc >= w_cap) ? '0 : w_idx_inc[AW-1:0];
                    end else if (!r_chk_vld) begin
                        // Nothing live in the window
                        n_read_ptr   = r_rp;
                        n_res.status = ST_UNDERFLOW;
                        n_state      = S_RES;
                    end
                end
            end
            S_RES: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_idx      <= '0;
            r_read_ptr <= '0;
            r_fill     <= '0;
            r_min_seq  <= '0;
            r_started  <= 1'b0;
            r_chk_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_read_ptr <= n_read_ptr;
            r_fill     <= n_fill;
            r_min_seq  <= n_min_seq;
            r_started  <= n_started;
            r_chk_vld  <= n_chk_vld;
        end
        r_item    <= n_item;
        r_res     <= n_res;
        r_rp      <= n_rp;
        r_cnt     <= n_cnt;
        r_chk_idx <= n_chk_idx;
        r_slot    <= n_slot;
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_res_valid    = (r_state == S_RES);
    assign o_res          = r_res;
    assign o_mod_dividend = r_read_ptr;
    assign o_mod_divisor  = w_cap;

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench - self-checking bench for the RTP jitter buffer reorder ring
// Streams add and read beats into the ring and predicts every response with
// a cycle-free model of the slot store, fill level and sequence window. A
// directed opening covers the wrap, drop, overflow, underflow, expiry and
// stale-slot cases. Random traffic phases follow, with varied ring settings
// and randomized back-pressure on both streams.
// ============================================================================

module testbench;
    import rtpjb_pkg::*;

    localparam int RING_DEPTH = 64;
    localparam int HOLD_CYCLES = 400;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [CIDX_W-1:0]  i_cfg_index = '0;
    logic [CDATA_W-1:0] i_cfg_data = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [95:0]        s_axis_tdata = '0;   // seq_num, payload_tag, payload_length, now_ms
    logic [0:0]         s_axis_tuser = '0;   // func
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [79:0]        m_axis_tdata;        // out_seq, out_tag, out_length, lost_count
    logic [2:0]         m_axis_tuser;        // status, out_valid

    // Predicted register contents
    logic [CNTR_W-1:0] cap_reg = CAPACITY_RESET;
    logic [DLY_W-1:0]  delay_reg = MAX_DELAY_RESET;
    logic [CNTR_W-1:0] fill_reg = MIN_FILL_RESET;

    // Predicted ring contents and window state
    bit                ring_live [RING_DEPTH];
    logic [SEQ_W-1:0]  ring_seq [RING_DEPTH];
    logic [TAG_W-1:0]  ring_tag [RING_DEPTH];
    logic [LEN_W-1:0]  ring_len [RING_DEPTH];
    logic [TIME_W-1:0] ring_stamp [RING_DEPTH];
    int unsigned       rd_ptr = 0;
    int unsigned       fill_lvl = 0;
    logic [SEQ_W-1:0]  base_seq = '0;
    bit                seq_locked = 1'b0;

    // Stimulus and response bookkeeping
    t_item       pkt_q [$];
    t_result     pending_rsp [$];
    t_item       beat_item;
    t_result     rsp_want;
    bit          in_taken = 1'b0;
    int unsigned n_items = 0;
    int unsigned errors = 0;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned hold_asked = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    logic [TIME_W-1:0] gen_ms = 32'hFFFF_FC00;

    // Random phase plan: ring settings, idling and length
    int unsigned ph_cap [7]   = '{64, 8, 2, 0, 127, 33, 64};
    int unsigned ph_delay [7] = '{100, 20, 0, 65535, 50, 1000, 100};
    int unsigned ph_fill [7]  = '{0, 2, 0, 1, 127, 0, 0};
    int unsigned ph_tx [7]    = '{0, 59, 0, 37, 0, 37, 0};
    int unsigned ph_rx [7]    = '{0, 0, 59, 37, 0, 37, 0};
    int unsigned ph_len [7]   = '{300, 300, 250, 250, 100, 250, 300};

    rtp_jitter_buffer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    // Ring size in use, saturated into the legal range
    function automatic int unsigned ring_slots();
        if (cap_reg < 2) return 2;
        if (cap_reg > RING_DEPTH) return RING_DEPTH;
        return 32'(cap_reg);
    endfunction

    // Apply one packet operation to the ring and return the response
    function automatic t_result ring_apply(input logic func, input logic [SEQ_W-1:0] seq,
                                           input logic [TAG_W-1:0] tag,
                                           input logic [LEN_W-1:0] len,
                                           input logic [TIME_W-1:0] now);
        int unsigned       cap;
        int unsigned       rp;
        int unsigned       idx;
        int unsigned       n;
        logic [SEQ_W-1:0]  ahead;
        logic [TIME_W-1:0] age;
        t_result           res;
        res = '0;
        cap = ring_slots();
        rp = rd_ptr % cap;
        if (func == FUNC_ADD) begin
            if (!seq_locked) begin
                base_seq = seq;
                seq_locked = 1'b1;
            end
            ahead = seq - base_seq;
            // behind the window: drop without complaint
            if (ahead[SEQ_W-1]) return res;
            if (fill_lvl >= cap || ahead >= cap) begin
                res.status = ST_OVERFLOW;
                return res;
            end
            idx = (rp + ahead) % cap;
            if (!ring_live[idx]) fill_lvl++;
            ring_live[idx] = 1'b1;
            ring_seq[idx] = seq;
            ring_tag[idx] = tag;
            ring_len[idx] = len;
            ring_stamp[idx] = now;
            return res;
        end
        if (fill_lvl < fill_reg) begin
            res.status = ST_UNDERFLOW;
            return res;
        end
        // Scan from the read pointer: expire old slots, skip stale ones
        idx = rp;
        for (n = 0; n + 1 < cap; n++) begin
            if (ring_live[idx]) begin
                age = now - ring_stamp[idx];
                ahead = ring_seq[idx] - base_seq;
                if (age > delay_reg) begin
                    ring_live[idx] = 1'b0;
                    if (fill_lvl > 0) fill_lvl--;
                end else if (!ahead[SEQ_W-1]) begin
                    res.valid = 1'b1;
                    res.seq = ring_seq[idx];
                    res.tag = ring_tag[idx];
                    res.len = ring_len[idx];
                    res.lost = ahead;
                    ring_live[idx] = 1'b0;
                    if (fill_lvl > 0) fill_lvl--;
                    rd_ptr = (idx + 1) % cap;
                    base_seq = ring_seq[idx] + 1'b1;
                    return res;
                end
            end
            idx = (idx + 1) % cap;
        end
        rd_ptr = rp;
        res.status = ST_UNDERFLOW;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    function automatic void queue_add(input logic [SEQ_W-1:0] seq, input logic [TAG_W-1:0] tag,
                                      input logic [LEN_W-1:0] len, input logic [TIME_W-1:0] now);
        t_item it;
        it.func = FUNC_ADD;
        it.seq = seq;
        it.tag = tag;
        it.len = len;
        it.now = now;
        pkt_q.push_back(it);
        n_items++;
    endfunction

    function automatic void queue_read(input logic [TIME_W-1:0] now);
        t_item it;
        it = '0;
        it.func = FUNC_READ;
        it.now = now;
        pkt_q.push_back(it);
        n_items++;
    endfunction

    // Hold until every queued beat is in and every response is back
    task automatic settle();
        do @(posedge i_clk);
        while (pkt_q.size() != 0 || s_axis_tvalid || pending_rsp.size() != 0);
        repeat (RING_DEPTH + 8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input int unsigned val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[CDATA_W-1:0];
        do @(posedge i_clk);
        while (!o_cfg_ready);
        case (idx)
            CFG_CAPACITY:  cap_reg = val[CNTR_W-1:0];
            CFG_MAX_DELAY: delay_reg = val[DLY_W-1:0];
            CFG_MIN_FILL:  fill_reg = val[CNTR_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // One window of reordered, partly lost packets followed by reads
    task automatic queue_burst();
        logic [SEQ_W-1:0] order [$];
        logic [SEQ_W-1:0] s;
        int unsigned      cap;
        int unsigned      kmax;
        int unsigned      k;
        int unsigned      j;
        int unsigned      pick;
        cap = ring_slots();
        kmax = ($urandom_range(9) == 0) ? cap + 1 : ((cap < 8) ? cap + 1 : 8);
        k = $urandom_range(1, kmax);
        for (j = 0; j < k; j++) begin
            s = base_seq + j[SEQ_W-1:0];
            if ($urandom_range(9) != 0) order.push_back(s);
        end
        for (j = 0; j < order.size(); j++) begin
            pick = $urandom_range(0, order.size() - 1);
            s = order[j];
            order[j] = order[pick];
            order[pick] = s;
        end
        for (j = 0; j < order.size(); j++) begin
            queue_add(order[j], $urandom, 16'($urandom_range(0, 65535)), gen_ms);
            gen_ms += $urandom_range(0, 3);
        end
        if (order.size() != 0 && $urandom_range(9) == 0)
            queue_add(order[0], $urandom, 16'($urandom_range(0, 65535)), gen_ms);
        repeat (k + $urandom_range(0, 1)) begin
            queue_read(gen_ms);
            gen_ms += $urandom_range(0, 2);
        end
        // Occasional noise: wild beats and clock jumps that expire slots
        case ($urandom_range(19))
            0: queue_add(16'($urandom_range(0, 65535)), $urandom,
                         16'($urandom_range(0, 65535)), $urandom);
            1: queue_read($urandom);
            2: gen_ms += $urandom_range(50, 3000);
            default: ;
        endcase
    endtask

    // Input driver: present the next beat once the previous one is taken
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || in_taken)) begin
            if (pkt_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                beat_item = pkt_q.pop_front();
                s_axis_tdata <= {beat_item.now, beat_item.len, beat_item.tag, beat_item.seq};
                s_axis_tuser <= beat_item.func;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output back-pressure, with a long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Monitor: predict on input beats, check output beats
    always @(posedge i_clk) begin
        in_taken <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            pending_rsp.push_back(ring_apply(s_axis_tuser[0], s_axis_tdata[15:0],
                                             s_axis_tdata[47:16], s_axis_tdata[63:48],
                                             s_axis_tdata[95:64]));
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected response beat: tuser %0h, tdata %0h",
                         $time, m_axis_tuser, m_axis_tdata);
                errors++;
            end else begin
                rsp_want = pending_rsp.pop_front();
                check_field("status", 32'(rsp_want.status), 32'(m_axis_tuser[1:0]));
                check_field("out_valid", 32'(rsp_want.valid), 32'(m_axis_tuser[2]));
                check_field("out_seq", 32'(rsp_want.seq), 32'(m_axis_tdata[15:0]));
                check_field("out_tag", rsp_want.tag, m_axis_tdata[47:16]);
                check_field("out_length", 32'(rsp_want.len), 32'(m_axis_tdata[63:48]));
                check_field("lost_count", 32'(rsp_want.lost), 32'(m_axis_tdata[79:64]));
            end
        end
    end

    initial begin
        int unsigned ph;
        int unsigned stop_at;
        int unsigned mark;
        bit          mid_done;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: window opens just below the sequence wrap
        queue_read(32'h0000_0000);
        queue_add(16'hFFFE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFF0);
        queue_add(16'h0001, 32'h0000_0000, 16'h0000, 32'hFFFF_FFF8);
        queue_add(16'hFFFE, 32'h1234_5678, 16'h0100, 32'hFFFF_FFF8);  // same slot again
        queue_add(16'h7FFE, 32'hDEAD_BEEF, 16'h0040, 32'hFFFF_FFF9);  // behind window
        queue_add(16'h003D, 32'h8000_0001, 16'h8000, 32'hFFFF_FFFC);  // last slot
        queue_add(16'h003E, 32'h0F0F_0F0F, 16'h00FF, 32'hFFFF_FFFC);  // one past the ring
        queue_read(32'h0000_0010);
        queue_read(32'h0000_0020);
        queue_read(32'h0000_1000);                                    // last slot expires
        queue_add(16'h0008, 32'hCAFE_0008, 16'h0008, 32'h0000_1000);
        settle();

        // Shrink the ring; the entry above stays outside it
        write_reg(CFG_CAPACITY, 4);
        write_reg(CFG_MAX_DELAY, 0);
        write_reg(CFG_MIN_FILL, 3);
        queue_read(32'h0000_1000);                                    // fill too low
        queue_add(16'h0003, 32'h0000_0003, 16'h0003, 32'h0000_1000);
        queue_add(16'h0004, 32'h0000_0004, 16'h0004, 32'h0000_1000);
        queue_add(16'h0005, 32'h0000_0005, 16'h0005, 32'h0000_1000);
        queue_add(16'h0002, 32'h0000_0002, 16'h0002, 32'h0000_1000);  // ring full
        queue_read(32'h0000_1000);
        queue_read(32'h0000_1001);                                    // all expire
        settle();

        write_reg(CFG_MIN_FILL, 0);
        write_reg(CFG_MAX_DELAY, 65535);
        queue_add(16'h0006, 32'h0000_0006, 16'h0006, 32'h0000_1002);
        queue_add(16'h0007, 32'h0000_0007, 16'h0007, 32'h0000_1002);
        queue_read(32'h0000_1002);
        queue_read(32'h0000_1002);
        queue_add(16'h0008, 32'h0000_0088, 16'h0088, 32'h0000_1003);
        queue_read(32'h0000_1003);
        settle();

        // Grow the ring back: the old entry is now behind the window
        write_reg(CFG_CAPACITY, 64);
        queue_read(32'h0000_1003);

        // Random traffic phases
        for (ph = 0; ph < 7; ph++) begin
            settle();
            write_reg(CFG_CAPACITY, ph_cap[ph]);
            write_reg(CFG_MAX_DELAY, ph_delay[ph]);
            write_reg(CFG_MIN_FILL, ph_fill[ph]);
            tx_idle_pct = ph_tx[ph];
            rx_stall_pct = ph_rx[ph];
            stop_at = n_items + ph_len[ph];
            mark = n_items + ph_len[ph] / 2;
            mid_done = 1'b0;
            while (n_items < stop_at) begin
                while (pkt_q.size() != 0) @(negedge i_clk);
                if (!mid_done && n_items >= mark) begin
                    mid_done = 1'b1;
                    // sender pause, then a long output hold-off
                    if (ph == 1) settle();
                    if (ph == 6) hold_asked++;
                end
                queue_burst();
            end
        end

        settle();
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #25_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
